// ===== rtl/core/prnf_pkg.sv =====
`default_nettype none
// ============================================================================
// prnf_pkg
// Shared widths, limit-curve tables and pipeline control types for the
// pulse ratio noise flag unit.
// ============================================================================
package prnf_pkg;

    // field widths
    localparam int CHARGE_W = 21;
    localparam int SUM_W    = 22;
    localparam int RATIO_W  = 16;
    localparam int QUO_W    = RATIO_W - 1;   // quotient magnitude bits below saturation
    localparam int SLOPE_W  = 8;
    localparam int LIMIT_W  = 22;

    // sums at or below 70 fC never flag
    localparam logic signed [SUM_W-1:0] SUM_FLOOR = 22'sd280;

    localparam logic signed [RATIO_W-1:0] RATIO_MAX = 16'sh7FFF;
    localparam logic signed [RATIO_W-1:0] RATIO_MIN = 16'sh8000;

    // segment counts (breakpoints minus one)
    localparam int UP_SEGS = 4;
    localparam int CH_SEGS = 6;
    localparam int GR_SEGS = 7;

    // remainder width of the divider: holds the shifted numerator and p << QUO_W
    function automatic int rem_width(input int frac_bits);
        rem_width = (CHARGE_W + frac_bits > CHARGE_W + QUO_W) ?
                    CHARGE_W + frac_bits : CHARGE_W + QUO_W;
    endfunction

    // one segment: start, slope step, start limit * dT, 100 * dT
    typedef struct packed {
        logic signed [SUM_W-1:0]   t;
        logic signed [SLOPE_W-1:0] dc;
        logic signed [LIMIT_W-1:0] cdt;
        logic signed [LIMIT_W-1:0] hdt;
    } seg_t;

    // limit terms of the selected segment
    typedef struct packed {
        logic [SUM_W-1:0]          pt;    // p minus segment start
        logic signed [SLOPE_W-1:0] dc;
        logic signed [LIMIT_W-1:0] cdt;
        logic signed [LIMIT_W-1:0] hdt;
    } lim_t;

    // control carried alongside the divider
    typedef struct packed {
        logic signed [SUM_W-1:0] p;
        logic                    neg;         // difference is negative
        logic                    over_floor;  // sum above floor
        logic                    ovf;         // quotient magnitude >= 2^QUO_W
        logic                    lo_open;     // at or below first lower breakpoint
        lim_t                    up;
        lim_t                    lo;
    } ctl_t;

    function automatic seg_t mk_seg(input int t, input int dc, input int cdt, input int hdt);
        seg_t s;
        s.t   = SUM_W'(t);
        s.dc  = SLOPE_W'(dc);
        s.cdt = LIMIT_W'(cdt);
        s.hdt = LIMIT_W'(hdt);
        return s;
    endfunction

    // upper curve
    function automatic seg_t up_seg(input logic [1:0] k);
        seg_t s;
        case (k)
            2'd0:    s = mk_seg(280, -20, 8000, 8000);
            2'd1:    s = mk_seg(360, -5, 3200, 4000);
            2'd2:    s = mk_seg(400, -3, 90000, 120000);
            default: s = mk_seg(1600, 0, 1036800, 1440000);
        endcase
        return s;
    endfunction

    // per-channel lower curve
    function automatic seg_t ch_seg(input logic [2:0] k);
        seg_t s;
        case (k)
            3'd0:    s = mk_seg(400, 30, -8000, 8000);
            3'd1:    s = mk_seg(480, 20, -11200, 16000);
            3'd2:    s = mk_seg(640, 10, -8000, 16000);
            3'd3:    s = mk_seg(800, 10, -16000, 40000);
            3'd4:    s = mk_seg(1200, 40, -24000, 80000);
            default: s = mk_seg(2000, 0, 140000, 1400000);
        endcase
        return s;
    endfunction

    // per-group lower curve
    function automatic seg_t gr_seg(input logic [2:0] k);
        seg_t s;
        case (k)
            3'd0:    s = mk_seg(400, 30, -8000, 8000);
            3'd1:    s = mk_seg(480, 30, -8400, 12000);
            3'd2:    s = mk_seg(600, 20, -8000, 20000);
            3'd3:    s = mk_seg(800, 12, -8000, 40000);
            3'd4:    s = mk_seg(1200, 8, -3200, 40000);
            3'd5:    s = mk_seg(1600, 10, 0, 40000);
            default: s = mk_seg(2000, 0, 140000, 1400000);
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pulse_ratio_noise_flag_unit.sv =====
`default_nettype none
// ============================================================================
// pulse_ratio_noise_flag_unit
// Pulse asymmetry ratio and energy-dependent noise band check.
// ============================================================================
// Usage:
//   s_* carries one pulse item per accepted beat: two adjacent sample charges
//   in 0.25 fC units. m_* returns one result item per input item, in order:
//   the charge sum, the Q2.14 asymmetry ratio and the noisy flag.
//   cfg_wr_en / cfg_wr_data write the lower-curve mode bit (0 per channel,
//   1 per group); write it only while no item is in flight.
// Timing:
//   One item per clock sustained while m_tready stays high. The path from
//   acceptance to m_tvalid has two front stages, one divider stage per quotient
//   bit (15) and two check stages. The bit-per-stage divider sets the depth.
// Reset and stall:
//   rst_n clears every stage valid bit and the mode bit. Each stage holds its
//   item while the next is full and stalled, so a stalled receiver fills the
//   pipeline bubble by bubble before s_tready drops; nothing is lost.
// ============================================================================
module pulse_ratio_noise_flag_unit #(
    parameter int RATIO_FRAC_BITS = 14
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // cfg: lower-curve mode bit
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    // s_tdata: [20:0] charge_first, [41:21] charge_second, [47:42] zero
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,
    // m_tdata: [21:0] charge_sum, [37:22] asym_ratio, [39:38] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,
    // m_tuser: [0] noisy
    output logic             m_tuser
);

    localparam int RemW  = prnf_pkg::rem_width(RATIO_FRAC_BITS);
    localparam int Steps = prnf_pkg::QUO_W;
    localparam int CW    = prnf_pkg::CHARGE_W;

    logic mode_reg;

    // divider chain wiring
    logic                        dv_valid [Steps+1];
    logic                        dv_ready [Steps+1];
    prnf_pkg::ctl_t              dv_ctl   [Steps+1];
    logic [RemW-1:0]             dv_rem   [Steps+1];
    logic [prnf_pkg::QUO_W-1:0]  dv_quo   [Steps+1];

    logic                                   res_noisy;
    logic signed [prnf_pkg::SUM_W-1:0]      res_sum;
    logic signed [prnf_pkg::RATIO_W-1:0]    res_ratio;

    // mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            mode_reg <= cfg_wr_data;
        end
    end

    prnf_front #(
        .FRAC_BITS (RATIO_FRAC_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .charge_first  ($signed(s_tdata[CW-1:0])),
        .charge_second ($signed(s_tdata[2*CW-1:CW])),
        .mode          (mode_reg),
        .out_valid     (dv_valid[0]),
        .out_ready     (dv_ready[0]),
        .out_ctl       (dv_ctl[0]),
        .out_rem       (dv_rem[0])
    );

    assign dv_quo[0] = '0;

    // quotient bits from the top down, one stage each
    for (genvar g = 0; g < Steps; g++)
    begin : g_div
        prnf_div_step #(
            .FRAC_BITS (RATIO_FRAC_BITS),
            .STEP      (Steps - 1 - g)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[g]),
            .in_ready  (dv_ready[g]),
            .in_ctl    (dv_ctl[g]),
            .in_rem    (dv_rem[g]),
            .in_quo    (dv_quo[g]),
            .out_valid (dv_valid[g+1]),
            .out_ready (dv_ready[g+1]),
            .out_ctl   (dv_ctl[g+1]),
            .out_rem   (dv_rem[g+1]),
            .out_quo   (dv_quo[g+1])
        );
    end

    prnf_check #(
        .FRAC_BITS (RATIO_FRAC_BITS)
    ) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (dv_valid[Steps]),
        .in_ready   (dv_ready[Steps]),
        .in_ctl     (dv_ctl[Steps]),
        .in_quo     (dv_quo[Steps]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .noisy      (res_noisy),
        .charge_sum (res_sum),
        .asym_ratio (res_ratio)
    );

    // final remainder is not needed past the last step
    logic rem_unused;
    assign rem_unused = ^dv_rem[Steps];

    assign m_tdata = {2'b00, res_ratio, res_sum};
    assign m_tuser = res_noisy;

    // a flagged pulse always has a sum above the floor
    a_noisy_needs_sum: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> $signed(m_tdata[21:0]) > prnf_pkg::SUM_FLOOR)
        else $error("noisy flag set with sum at or below floor");

    // small sums report a zero ratio
    a_small_sum_zero_ratio: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !($signed(m_tdata[21:0]) > prnf_pkg::SUM_FLOOR)
        |-> m_tdata[37:22] == '0)
        else $error("nonzero ratio for small sum");

    // an empty output stage lets the whole chain accept
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output stage empty");

    // a result held by the receiver stays valid
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready && rem_unused == rem_unused |=> m_tvalid)
        else $error("result dropped under stall");

endmodule
`default_nettype wire

// ===== rtl/core/prnf_front.sv =====
`default_nettype none
// ============================================================================
// prnf_front
// Two pipeline stages: sum and difference magnitude, then segment lookup,
// overflow check and divider setup.
// ============================================================================
module prnf_front #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [prnf_pkg::CHARGE_W-1:0]  charge_first,
    input  wire logic signed [prnf_pkg::CHARGE_W-1:0]  charge_second,
    input  wire logic                                  mode,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output prnf_pkg::ctl_t                             out_ctl,
    output logic [prnf_pkg::rem_width(FRAC_BITS)-1:0]  out_rem
);

    localparam int RemW = prnf_pkg::rem_width(FRAC_BITS);
    localparam int CW   = prnf_pkg::CHARGE_W;
    localparam int SW   = prnf_pkg::SUM_W;

    // stage 1 registers
    logic                 s1_valid_reg;
    logic signed [SW-1:0] s1_p_reg;
    logic                 s1_neg_reg;
    logic [CW-1:0]        s1_mag_reg;
    logic                 s1_mode_reg;

    // stage 2 registers
    logic                 s2_valid_reg;
    prnf_pkg::ctl_t       s2_ctl_reg;
    logic [RemW-1:0]      s2_rem_reg;

    logic                 s1_ready;
    logic                 s2_ready;

    logic signed [SW-1:0] sum_next;
    logic signed [SW-1:0] diff_next;
    logic [SW-1:0]        abs_next;

    prnf_pkg::ctl_t       ctl_next;
    logic [RemW-1:0]      num_next;
    logic [RemW-1:0]      dlim_next;

    // handshake
    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // sum and difference magnitude
    always_comb
    begin
        sum_next  = {charge_first[CW-1], charge_first} + {charge_second[CW-1], charge_second};
        diff_next = {charge_first[CW-1], charge_first} - {charge_second[CW-1], charge_second};
        abs_next  = diff_next[SW-1] ? SW'(-diff_next) : diff_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_p_reg    <= sum_next;
            s1_neg_reg  <= diff_next[SW-1];
            s1_mag_reg  <= abs_next[CW-1:0];
            s1_mode_reg <= mode;
        end
    end

    // segment lookup and divider setup
    always_comb
    begin
        prnf_pkg::seg_t seg_up;
        prnf_pkg::seg_t seg_ch;
        prnf_pkg::seg_t seg_gr;
        prnf_pkg::seg_t seg_lo;
        prnf_pkg::seg_t tmp;
        logic [1:0]     up_bin;
        logic [2:0]     ch_bin;
        logic [2:0]     gr_bin;

        up_bin = '0;
        for (int k = 1; k < prnf_pkg::UP_SEGS; k++)
        begin
            tmp = prnf_pkg::up_seg(2'(k));
            if (s1_p_reg > tmp.t)
                up_bin = 2'(k);
        end
        ch_bin = '0;
        for (int k = 1; k < prnf_pkg::CH_SEGS; k++)
        begin
            tmp = prnf_pkg::ch_seg(3'(k));
            if (s1_p_reg > tmp.t)
                ch_bin = 3'(k);
        end
        gr_bin = '0;
        for (int k = 1; k < prnf_pkg::GR_SEGS; k++)
        begin
            tmp = prnf_pkg::gr_seg(3'(k));
            if (s1_p_reg > tmp.t)
                gr_bin = 3'(k);
        end

        seg_up = prnf_pkg::up_seg(up_bin);
        seg_ch = prnf_pkg::ch_seg(ch_bin);
        seg_gr = prnf_pkg::gr_seg(gr_bin);
        seg_lo = s1_mode_reg ? seg_gr : seg_ch;

        ctl_next.p          = s1_p_reg;
        ctl_next.neg        = s1_neg_reg;
        ctl_next.over_floor = s1_p_reg > prnf_pkg::SUM_FLOOR;
        // open until p passes the start of the first lower segment
        ctl_next.lo_open    = !(s1_p_reg > seg_lo.t);

        ctl_next.up.pt  = SW'(s1_p_reg - seg_up.t);
        ctl_next.up.dc  = seg_up.dc;
        ctl_next.up.cdt = seg_up.cdt;
        ctl_next.up.hdt = seg_up.hdt;
        ctl_next.lo.pt  = SW'(s1_p_reg - seg_lo.t);
        ctl_next.lo.dc  = seg_lo.dc;
        ctl_next.lo.cdt = seg_lo.cdt;
        ctl_next.lo.hdt = seg_lo.hdt;

        // quotient saturates when numerator >= p * 2^QUO_W
        num_next     = RemW'(s1_mag_reg) << FRAC_BITS;
        dlim_next    = RemW'(s1_p_reg[CW-1:0]) << prnf_pkg::QUO_W;
        ctl_next.ovf = num_next >= dlim_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_ctl_reg <= ctl_next;
            s2_rem_reg <= num_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_ctl   = s2_ctl_reg;
    assign out_rem   = s2_rem_reg;

endmodule
`default_nettype wire

// ===== rtl/core/prnf_div_step.sv =====
`default_nettype none
// ============================================================================
// prnf_div_step
// One restoring-division stage: resolves a single quotient bit.
// ============================================================================
module prnf_div_step #(
    parameter int FRAC_BITS = 14,
    parameter int STEP      = 0
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire prnf_pkg::ctl_t                        in_ctl,
    input  wire logic [prnf_pkg::rem_width(FRAC_BITS)-1:0] in_rem,
    input  wire logic [prnf_pkg::QUO_W-1:0]            in_quo,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output prnf_pkg::ctl_t                             out_ctl,
    output logic [prnf_pkg::rem_width(FRAC_BITS)-1:0]  out_rem,
    output logic [prnf_pkg::QUO_W-1:0]                 out_quo
);

    localparam int RemW = prnf_pkg::rem_width(FRAC_BITS);

    logic                         valid_reg;
    prnf_pkg::ctl_t               ctl_reg;
    logic [RemW-1:0]              rem_reg;
    logic [prnf_pkg::QUO_W-1:0]   quo_reg;

    logic                         stage_ready;
    logic [RemW-1:0]              dsh;
    logic                         ge;
    logic [RemW-1:0]              rem_next;
    logic [prnf_pkg::QUO_W-1:0]   quo_next;

    assign stage_ready = !valid_reg || out_ready;
    assign in_ready    = stage_ready;

    // trial subtract of the shifted divisor
    always_comb
    begin
        dsh            = RemW'(in_ctl.p[prnf_pkg::CHARGE_W-1:0]) << STEP;
        ge             = in_rem >= dsh;
        rem_next       = ge ? in_rem - dsh : in_rem;
        quo_next       = in_quo;
        quo_next[STEP] = ge;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (stage_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready && in_valid)
        begin
            ctl_reg <= in_ctl;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;

endmodule
`default_nettype wire

// ===== rtl/core/prnf_check.sv =====
`default_nettype none
// ============================================================================
// prnf_check
// Ratio saturation, limit products, exact band comparison and the output
// register.
// ============================================================================
module prnf_check #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire prnf_pkg::ctl_t                       in_ctl,
    input  wire logic [prnf_pkg::QUO_W-1:0]           in_quo,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic                                      noisy,
    output logic signed [prnf_pkg::SUM_W-1:0]         charge_sum,
    output logic signed [prnf_pkg::RATIO_W-1:0]       asym_ratio
);

    localparam int SW     = prnf_pkg::SUM_W;
    localparam int RW     = prnf_pkg::RATIO_W;
    localparam int LhsW   = prnf_pkg::RATIO_W + prnf_pkg::LIMIT_W;
    localparam int ProdW  = prnf_pkg::SUM_W + 1 + prnf_pkg::SLOPE_W;
    localparam int BaseW  = ProdW + 1;
    localparam int CmpW   = ((BaseW + FRAC_BITS > LhsW) ? BaseW + FRAC_BITS : LhsW) + 1;

    // product stage registers
    logic                                c_valid_reg;
    logic signed [SW-1:0]                c_p_reg;
    logic                                c_large_reg;
    logic                                c_lo_open_reg;
    logic signed [RW-1:0]                c_rq_reg;
    logic signed [LhsW-1:0]              c_lhs_up_reg;
    logic signed [LhsW-1:0]              c_lhs_lo_reg;
    logic signed [ProdW-1:0]             c_prod_up_reg;
    logic signed [ProdW-1:0]             c_prod_lo_reg;
    logic signed [prnf_pkg::LIMIT_W-1:0] c_cdt_up_reg;
    logic signed [prnf_pkg::LIMIT_W-1:0] c_cdt_lo_reg;

    // output registers
    logic                 e_valid_reg;
    logic                 e_noisy_reg;
    logic signed [SW-1:0] e_p_reg;
    logic signed [RW-1:0] e_rq_reg;

    logic                 c_ready;
    logic                 e_ready;

    logic signed [RW-1:0]    rq_next;
    logic signed [LhsW-1:0]  lhs_up_next;
    logic signed [LhsW-1:0]  lhs_lo_next;
    logic signed [ProdW-1:0] prod_up_next;
    logic signed [ProdW-1:0] prod_lo_next;

    logic signed [BaseW-1:0] base_up;
    logic signed [BaseW-1:0] base_lo;
    logic signed [CmpW-1:0]  rhs_up;
    logic signed [CmpW-1:0]  rhs_lo;
    logic                    trip_up;
    logic                    trip_lo;
    logic                    noisy_next;

    assign e_ready  = !e_valid_reg || out_ready;
    assign c_ready  = !c_valid_reg || e_ready;
    assign in_ready = c_ready;

    // saturated signed ratio, then the ratio and slope products
    always_comb
    begin
        if (!in_ctl.over_floor)
            rq_next = '0;
        else if (in_ctl.ovf)
            rq_next = in_ctl.neg ? prnf_pkg::RATIO_MIN : prnf_pkg::RATIO_MAX;
        else if (in_ctl.neg)
            rq_next = -$signed({1'b0, in_quo});
        else
            rq_next = $signed({1'b0, in_quo});

        lhs_up_next  = LhsW'(rq_next) * LhsW'(in_ctl.up.hdt);
        lhs_lo_next  = LhsW'(rq_next) * LhsW'(in_ctl.lo.hdt);
        prod_up_next = ProdW'($signed({1'b0, in_ctl.up.pt})) * ProdW'(in_ctl.up.dc);
        prod_lo_next = ProdW'($signed({1'b0, in_ctl.lo.pt})) * ProdW'(in_ctl.lo.dc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_ready)
        begin
            c_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && in_valid)
        begin
            c_p_reg       <= in_ctl.p;
            c_large_reg   <= in_ctl.over_floor;
            c_lo_open_reg <= in_ctl.lo_open;
            c_rq_reg      <= rq_next;
            c_lhs_up_reg  <= lhs_up_next;
            c_lhs_lo_reg  <= lhs_lo_next;
            c_prod_up_reg <= prod_up_next;
            c_prod_lo_reg <= prod_lo_next;
            c_cdt_up_reg  <= in_ctl.up.cdt;
            c_cdt_lo_reg  <= in_ctl.lo.cdt;
        end
    end

    // limit at p scaled by dT and 2^FRAC_BITS, compared exactly
    always_comb
    begin
        base_up    = BaseW'(c_prod_up_reg) + BaseW'(c_cdt_up_reg);
        base_lo    = BaseW'(c_prod_lo_reg) + BaseW'(c_cdt_lo_reg);
        rhs_up     = CmpW'(base_up) <<< FRAC_BITS;
        rhs_lo     = CmpW'(base_lo) <<< FRAC_BITS;
        trip_up    = CmpW'(c_lhs_up_reg) > rhs_up;
        trip_lo    = !c_lo_open_reg && (CmpW'(c_lhs_lo_reg) < rhs_lo);
        noisy_next = c_large_reg && (trip_up || trip_lo);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (e_ready)
        begin
            e_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_ready && c_valid_reg)
        begin
            e_noisy_reg <= noisy_next;
            e_p_reg     <= c_p_reg;
            e_rq_reg    <= c_rq_reg;
        end
    end

    assign out_valid  = e_valid_reg;
    assign noisy      = e_noisy_reg;
    assign charge_sum = e_p_reg;
    assign asym_ratio = e_rq_reg;

endmodule
`default_nettype wire

// ===== tb/pulse_ratio_noise_flag_unit_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// pulse_ratio_noise_flag_unit_tb
// Streams pulse charge pairs through the noise flag unit under both lower
// curve modes. Each accepted item is rated by an in-bench integer predictor
// and the returned sum, ratio and noisy flag are checked in order. Sender
// bursts, receiver stalls and one long receiver hold-off exercise the
// pipeline backpressure.
// ============================================================================
module pulse_ratio_noise_flag_unit_tb;

    localparam int RATIO_FRAC_BITS = 14;
    localparam int CHARGE_W = prnf_pkg::CHARGE_W;
    localparam int SUM_W    = prnf_pkg::SUM_W;
    localparam int RATIO_W  = prnf_pkg::RATIO_W;

    // lower curve mode register codes
    localparam bit MODE_CHANNEL = 1'b0;
    localparam bit MODE_GROUP   = 1'b1;

    // charge range driven on each sample
    localparam longint CHARGE_LO = -131072;
    localparam longint CHARGE_HI = 1048575;

    typedef enum int {
        CURVE_UPPER   = 0,
        CURVE_CHANNEL = 1,
        CURVE_GROUP   = 2
    } curve_e;

    typedef struct {
        logic                      noisy;
        logic signed [SUM_W-1:0]   sum;
        logic signed [RATIO_W-1:0] ratio;
    } pulse_rating_t;

    // limit curves: breakpoints in 0.25 fC, limits in hundredths
    longint knee_sum [3][8] = '{
        '{280, 360, 400, 1600, 16000, 0, 0, 0},
        '{400, 480, 640, 800, 1200, 2000, 16000, 0},
        '{400, 480, 600, 800, 1200, 1600, 2000, 16000}
    };
    longint knee_lim [3][8] = '{
        '{100, 80, 75, 72, 72, 0, 0, 0},
        '{-100, -70, -50, -40, -30, 10, 10, 0},
        '{-100, -70, -40, -20, -8, 0, 10, 10}
    };
    int knee_count [3] = '{5, 7, 8};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;

    logic [47:0]   pulse_queue [$];
    pulse_rating_t rated_pulses [$];
    bit            curve_mode = MODE_CHANNEL;
    bit            in_fire = 1'b0;
    int            results_seen = 0;
    int            errors = 0;

    // sender burst state
    int burst_left = 1;
    int gap_left = 0;

    // receiver stall state
    int  pace_left = 0;
    int  ready_pct = 100;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    pulse_ratio_noise_flag_unit #(
        .RATIO_FRAC_BITS(RATIO_FRAC_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // true when ratio rq lies past the curve's limit at sum p
    function automatic bit past_limit(input int curve, input longint p, input longint rq,
                                      input bit upper);
        int     bin;
        longint dt;
        longint dc;
        longint lhs;
        longint rhs;
        bin = -1;
        for (int j = 0; j < knee_count[curve] - 1; j++)
        begin
            if (knee_sum[curve][j] < p)
                bin = j;
        end
        // at or below the first breakpoint the limit is open
        if (bin < 0)
            return 1'b0;
        dt  = knee_sum[curve][bin + 1] - knee_sum[curve][bin];
        dc  = knee_lim[curve][bin + 1] - knee_lim[curve][bin];
        lhs = rq * 100 * dt;
        rhs = (knee_lim[curve][bin] * dt + (p - knee_sum[curve][bin]) * dc)
              * (longint'(1) << RATIO_FRAC_BITS);
        return upper ? (lhs > rhs) : (lhs < rhs);
    endfunction

    function automatic pulse_rating_t rate_pulse(input logic signed [CHARGE_W-1:0] a,
                                                 input logic signed [CHARGE_W-1:0] b,
                                                 input bit mode);
        pulse_rating_t r;
        longint        p;
        longint        rq;
        bit            hit;
        p   = longint'(a) + longint'(b);
        rq  = 0;
        hit = 1'b0;
        // small or negative sums skip the division and never flag
        if (p > longint'(prnf_pkg::SUM_FLOOR))
        begin
            rq = ((longint'(a) - longint'(b)) * (longint'(1) << RATIO_FRAC_BITS)) / p;
            if (rq > longint'(prnf_pkg::RATIO_MAX))
                rq = longint'(prnf_pkg::RATIO_MAX);
            if (rq < longint'(prnf_pkg::RATIO_MIN))
                rq = longint'(prnf_pkg::RATIO_MIN);
            hit = past_limit((mode == MODE_GROUP) ? CURVE_GROUP : CURVE_CHANNEL, p, rq, 1'b0)
                  || past_limit(CURVE_UPPER, p, rq, 1'b1);
        end
        r.noisy = hit;
        r.sum   = SUM_W'(p);
        r.ratio = RATIO_W'(rq);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    task automatic add_pulse(input longint a, input longint b);
        pulse_queue.push_back({6'b0, CHARGE_W'(b), CHARGE_W'(a)});
    endtask

    // fixed corner pulses
    task automatic queue_corners();
        add_pulse(0, 0);
        add_pulse(CHARGE_LO, CHARGE_LO);
        add_pulse(CHARGE_HI, CHARGE_HI);
        add_pulse(CHARGE_HI, CHARGE_LO);
        add_pulse(CHARGE_LO, CHARGE_HI);
        add_pulse(CHARGE_HI, 0);
        add_pulse(140, 140);        // sum exactly on the floor
        add_pulse(141, 140);        // just above the floor
        add_pulse(281, 0);          // ratio 1 at the first upper breakpoint
        add_pulse(-1, 282);
        add_pulse(390, 0);          // lower limit still open
        add_pulse(0, 390);
        add_pulse(0, 400);          // sum on the first lower breakpoint
        add_pulse(0, 401);
        add_pulse(3000, -1000);     // positive saturation
        add_pulse(-1100, 3000);     // negative saturation
        add_pulse(-700, 1500);
        add_pulse(200, 600);
        add_pulse(600, 600);
        add_pulse(1000, 600);
        add_pulse(1100, 900);       // ratio 0.1 at sum 500 fC
        add_pulse(8000, 8000);      // last breakpoint
        add_pulse(8001, 8000);      // beyond the last breakpoint
    endtask

    // random pulses: mostly near the band, some noise and saturating pairs
    task automatic queue_random(input int count);
        longint p;
        longint a;
        longint b;
        int     kind;
        int     c;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                a = longint'($urandom_range(0, CHARGE_HI - CHARGE_LO)) + CHARGE_LO;
                b = longint'($urandom_range(0, CHARGE_HI - CHARGE_LO)) + CHARGE_LO;
            end
            else if (kind == 1)
            begin
                a = $urandom_range(1000, 200000);
                b = -longint'($urandom_range(a / 3, a - 300));
                if ($urandom_range(0, 1))
                begin
                    p = a;
                    a = b;
                    b = p;
                end
            end
            else
            begin
                if (kind == 2)
                    p = $urandom_range(250, 420);
                else if (kind == 3)
                begin
                    c = $urandom_range(0, 2);
                    p = knee_sum[c][$urandom_range(0, knee_count[c] - 1)]
                        + longint'($urandom_range(0, 2)) - 1;
                end
                else if ($urandom_range(0, 7) == 0)
                    p = $urandom_range(250, 200000);
                else
                    p = $urandom_range(250, 18000);
                // ratio spread over roughly -1.2 .. 1.2
                a = longint'($urandom_range(0, p * 12 / 10)) - p / 10;
                b = p - a;
            end
            add_pulse(a, b);
        end
    endtask

    task automatic wait_drained();
        while (pulse_queue.size() != 0 || s_tvalid || rated_pulses.size() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    task automatic write_mode(input bit mode);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // sender: bursts of random length with random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_fire))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pulse_queue.size() != 0)
            begin
                s_tdata  <= pulse_queue.pop_front();
                s_tvalid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left--;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: paced stalls, plus one long hold-off once traffic is flowing
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (!hold_done && results_seen >= 300)
        begin
            hold_done = 1'b1;
            hold_left = 250;
            m_tready <= 1'b0;
        end
        else
        begin
            if (pace_left == 0)
            begin
                pace_left = 64;
                case ($urandom_range(0, 3))
                    0:       ready_pct = 100;
                    1:       ready_pct = 75;
                    2:       ready_pct = 40;
                    default: ready_pct = 10;
                endcase
            end
            pace_left--;
            m_tready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    // monitor: track mode, rate accepted pulses, check returned items
    always @(posedge clk)
    begin
        pulse_rating_t want;
        in_fire <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (cfg_wr_en)
                curve_mode <= cfg_wr_data;
            if (s_tvalid && s_tready)
                rated_pulses.push_back(rate_pulse(s_tdata[CHARGE_W-1:0],
                                                  s_tdata[2*CHARGE_W-1:CHARGE_W], curve_mode));
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (rated_pulses.size() == 0)
                    report_mismatch("unexpected item", m_tdata, 0);
                else
                begin
                    want = rated_pulses.pop_front();
                    if (m_tuser !== want.noisy)
                        report_mismatch("noisy", m_tuser, want.noisy);
                    if ($signed(m_tdata[SUM_W-1:0]) !== want.sum)
                        report_mismatch("charge_sum", $signed(m_tdata[SUM_W-1:0]), want.sum);
                    if ($signed(m_tdata[SUM_W+RATIO_W-1:SUM_W]) !== want.ratio)
                        report_mismatch("asym_ratio", $signed(m_tdata[SUM_W+RATIO_W-1:SUM_W]),
                                        want.ratio);
                end
            end
        end
    end

    // stimulus phases
    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_mode(MODE_CHANNEL);
        queue_corners();
        queue_random(240);
        wait_drained();

        write_mode(MODE_GROUP);
        queue_corners();
        queue_random(240);
        wait_drained();

        write_mode(MODE_CHANNEL);
        queue_random(235);
        wait_drained();

        write_mode(MODE_GROUP);
        queue_random(235);
        wait_drained();

        if (rated_pulses.size() != 0)
            report_mismatch("missing items", 0, rated_pulses.size());
        if (errors == 0)
            $display("[pulse_ratio_noise_flag_unit] OK");
        else
            $display("[pulse_ratio_noise_flag_unit] ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #3000000;
        $display("[pulse_ratio_noise_flag_unit] ERROR");
        $finish;
    end

endmodule

// ===== pulse_ratio_noise_flag_unit.f =====
rtl/core/prnf_pkg.sv
rtl/core/prnf_front.sv
rtl/core/prnf_div_step.sv
rtl/core/prnf_check.sv
rtl/core/pulse_ratio_noise_flag_unit.sv
tb/pulse_ratio_noise_flag_unit_tb.sv
